/* hw/rtl/chsu_pkg.sv */
// ----------------------------------------------------------------------------
// chsu_pkg
// Shared types, constants and fixed-point helpers for the spectral update core.
// ----------------------------------------------------------------------------
package chsu_pkg;

    localparam int FRAC_BITS  = 20;
    localparam int WORD_BITS  = 32;
    localparam int GRID_W     = 11;
    localparam int INDEX_W    = 10;
    localparam int REG_W      = 31;
    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int DIV_STEPS  = 32;
    localparam int FRONT_ST   = 11;

    localparam logic [GRID_W-1:0] GRID_LIMIT = 11'd1024;

    typedef logic signed [WORD_BITS-1:0] t_fix;
    typedef logic signed [11:0]          t_wave_idx;

    localparam t_fix ONE_FIX = 32'sd1048576;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_ROWS  = 3'd0,
        REG_GRID_COLS  = 3'd1,
        REG_FSTEP_ROW  = 3'd2,
        REG_FSTEP_COL  = 3'd3,
        REG_GRAD_COEFF = 3'd4,
        REG_BARRIER    = 3'd5,
        REG_TIME_STEP  = 3'd6
    } t_reg_idx;

    function automatic t_fix sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    function automatic t_fix add_sat(input t_fix a, input t_fix b);
        return sat33({a[31], a} + {b[31], b});
    endfunction

    function automatic t_fix sub_sat(input t_fix a, input t_fix b);
        return sat33({a[31], a} - {b[31], b});
    endfunction

    function automatic t_fix sat44(input logic signed [43:0] v);
        if (v[43:31] != {13{v[43]}}) begin
            return v[43] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    // round half away from zero, drop the fraction, saturate
    function automatic t_fix rnd(input logic signed [63:0] p);
        logic        neg;
        logic [63:0] m;
        logic [64:0] mr;
        logic [44:0] q;
        logic [31:0] lim;
        neg = p[63];
        m   = neg ? (64'd0 - $unsigned(p)) : $unsigned(p);
        mr  = {1'b0, m} + (65'd1 << (FRAC_BITS - 1));
        q   = mr[64:FRAC_BITS];
        lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        if (q > {13'd0, lim}) begin
            q = {13'd0, lim};
        end
        return neg ? t_fix'(32'd0 - q[31:0]) : t_fix'(q[31:0]);
    endfunction

    function automatic t_wave_idx fold(input logic [INDEX_W-1:0] idx,
                                       input logic [GRID_W-1:0]  n);
        logic [GRID_W-1:0] nc;
        nc = (n > GRID_LIMIT) ? GRID_LIMIT : n;
        if ({1'b0, idx} < (nc >> 1)) begin
            return t_wave_idx'({2'b00, idx});
        end
        return $signed({2'b00, idx}) - $signed({1'b0, nc});
    endfunction

endpackage

/* hw/rtl/chsu_div.sv */
// ----------------------------------------------------------------------------
// chsu_div
// Pipelined restoring divider, two lanes, one quotient bit per stage, with
// rounding and saturation; carries the bulk result of kind 0 items alongside.
// ----------------------------------------------------------------------------
module chsu_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  chsu_pkg::t_fix          i_num_re,
    input  chsu_pkg::t_fix          i_num_im,
    input  logic [30:0]             i_den,
    input  logic                    i_kind,
    input  chsu_pkg::t_fix          i_bulk,
    output logic                    o_valid,
    input  logic                    i_ready,
    output chsu_pkg::t_fix          o_res_re,
    output chsu_pkg::t_fix          o_res_im
);
    import chsu_pkg::*;

    localparam int NS = DIV_STEPS + 2;

    logic [NS-1:0] r_vld;
    logic [NS:0]   w_ce;

    logic [31:0] r_rem  [DIV_STEPS+1][2];
    logic [31:0] r_quo  [DIV_STEPS+1][2];
    logic [31:0] r_dl   [DIV_STEPS+1][2];
    logic        r_neg  [DIV_STEPS+1][2];
    logic        r_ovf  [DIV_STEPS+1][2];
    logic [30:0] r_den  [DIV_STEPS+1];
    logic        r_kind [DIV_STEPS+1];
    t_fix        r_bulk [DIV_STEPS+1];

    t_fix r_res_re;
    t_fix r_res_im;
    t_fix w_num [2];
    t_fix w_fin [2];

    assign w_num[0] = i_num_re;
    assign w_num[1] = i_num_im;

    always_comb begin
        w_ce[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_ce[k] = !r_vld[k] || w_ce[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ce[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (w_ce[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_prep
        logic        w_neg;
        logic [31:0] w_mag;
        assign w_neg = w_num[l][31];
        assign w_mag = w_neg ? (32'd0 - $unsigned(w_num[l])) : $unsigned(w_num[l]);
        always_ff @(posedge i_clk) begin
            if (w_ce[0]) begin
                r_neg[0][l] <= w_neg;
                r_ovf[0][l] <= {11'd0, w_mag[31:12]} >= i_den;
                r_rem[0][l] <= {12'd0, w_mag[31:12]};
                r_dl[0][l]  <= {w_mag[11:0], 20'd0};
                r_quo[0][l] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce[0]) begin
            r_den[0]  <= i_den;
            r_kind[0] <= i_kind;
            r_bulk[0] <= i_bulk;
        end
    end

    for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [31:0] w_try;
            logic        w_ge;
            assign w_try = {r_rem[s-1][l][30:0], r_dl[s-1][l][31]};
            assign w_ge  = w_try >= {1'b0, r_den[s-1]};
            always_ff @(posedge i_clk) begin
                if (w_ce[s]) begin
                    r_rem[s][l] <= w_ge ? (w_try - {1'b0, r_den[s-1]}) : w_try;
                    r_quo[s][l] <= {r_quo[s-1][l][30:0], w_ge};
                    r_dl[s][l]  <= {r_dl[s-1][l][30:0], 1'b0};
                    r_neg[s][l] <= r_neg[s-1][l];
                    r_ovf[s][l] <= r_ovf[s-1][l];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_ce[s]) begin
                r_den[s]  <= r_den[s-1];
                r_kind[s] <= r_kind[s-1];
                r_bulk[s] <= r_bulk[s-1];
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_fin
        logic        w_up;
        logic [32:0] w_qr;
        logic [32:0] w_lim;
        logic [32:0] w_mag;
        assign w_up  = {r_rem[DIV_STEPS][l], 1'b0} >= {2'b00, r_den[DIV_STEPS]};
        assign w_qr  = {1'b0, r_quo[DIV_STEPS][l]} + {32'd0, w_up};
        assign w_lim = r_neg[DIV_STEPS][l] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
        assign w_mag = (r_ovf[DIV_STEPS][l] || (w_qr > w_lim)) ? w_lim : w_qr;
        assign w_fin[l] = r_neg[DIV_STEPS][l] ? t_fix'(32'd0 - w_mag[31:0])
                                              : t_fix'(w_mag[31:0]);
    end

    always_ff @(posedge i_clk) begin
        if (w_ce[NS-1]) begin
            r_res_re <= r_kind[DIV_STEPS] ? w_fin[0] : r_bulk[DIV_STEPS];
            r_res_im <= r_kind[DIV_STEPS] ? w_fin[1] : '0;
        end
    end

    assign o_ready  = w_ce[0];
    assign o_valid  = r_vld[NS-1];
    assign o_res_re = r_res_re;
    assign o_res_im = r_res_im;

endmodule

/* hw/rtl/cahn_hilliard_spectral_update_core.sv */
// ----------------------------------------------------------------------------
// cahn_hilliard_spectral_update_core
// Pointwise arithmetic of a semi-implicit spectral Cahn-Hilliard step.
// ----------------------------------------------------------------------------
// Input stream carries one grid point per item; tuser selects the work:
// 0 forms the bulk driving force from c in value_re, 1 forms the spectral
// update (C - k2*dt*G) / (1 + 2*kappa*k4*dt) from indices and C, G.
// Output stream carries one complex Q11.20 result per item.
// 11 arithmetic stages (a fold stage, then multiply stages alternating
// with rounding stages), 32 divider stages at one quotient bit each, one
// prepare and one round/output stage; one item per cycle unless stalled.
// Valid bits travel with the data; a stage loads whenever it or any stage
// downstream is empty, so a stalled receiver holds the output register and
// the input keeps accepting until the pipeline is full.
// Reset clears all valid bits and loads register defaults; configuration
// writes take effect at any edge with i_cfg_we high, also on items in flight.
// ----------------------------------------------------------------------------
module cahn_hilliard_spectral_update_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // row_index, col_index, value_re, value_im, drive_re, drive_im, pad
    input  logic [chsu_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // kind
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // result_re, result_im
    output logic [chsu_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [chsu_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [chsu_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import chsu_pkg::*;

    logic [GRID_W-1:0] r_grid_rows, r_grid_cols;
    logic [REG_W-1:0]  r_fsr, r_fsc, r_kap, r_bh, r_dt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= 11'd256;
            r_grid_cols <= 11'd256;
            r_fsr       <= 31'd25736;
            r_fsc       <= 31'd25736;
            r_kap       <= 31'd1048576;
            r_bh        <= 31'd1048576;
            r_dt        <= 31'd1048576;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_GRID_ROWS:  r_grid_rows <= i_cfg_data[GRID_W-1:0];
                REG_GRID_COLS:  r_grid_cols <= i_cfg_data[GRID_W-1:0];
                REG_FSTEP_ROW:  r_fsr       <= i_cfg_data;
                REG_FSTEP_COL:  r_fsc       <= i_cfg_data;
                REG_GRAD_COEFF: r_kap       <= i_cfg_data;
                REG_BARRIER:    r_bh        <= i_cfg_data;
                REG_TIME_STEP:  r_dt        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [INDEX_W-1:0] w_row, w_col;
    t_fix               w_vre, w_vim, w_dre, w_dim;

    assign w_row = i_s_axis_tdata[9:0];
    assign w_col = i_s_axis_tdata[19:10];
    assign w_vre = i_s_axis_tdata[51:20];
    assign w_vim = i_s_axis_tdata[83:52];
    assign w_dre = i_s_axis_tdata[115:84];
    assign w_dim = i_s_axis_tdata[147:116];

    logic [FRONT_ST-1:0] r_vf;
    logic [FRONT_ST:0]   w_cf;
    logic                w_div_rdy;

    always_comb begin
        w_cf[FRONT_ST] = w_div_rdy;
        for (int k = FRONT_ST - 1; k >= 0; k--) begin
            w_cf[k] = !r_vf[k] || w_cf[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= '0;
        end else begin
            if (w_cf[0]) r_vf[0] <= i_s_axis_tvalid;
            for (int k = 1; k < FRONT_ST; k++) begin
                if (w_cf[k]) r_vf[k] <= r_vf[k-1];
            end
        end
    end

    logic               r1_kind, r2_kind, r3_kind, r4_kind, r5_kind, r6_kind;
    logic               r7_kind, r8_kind, r9_kind, r10_kind, r11_kind;
    t_wave_idx          r1_fr, r1_fc;
    t_fix               r1_vre, r1_vim, r1_dre, r1_dim, r1_u, r1_w;
    logic signed [43:0] r2_pkx, r2_pky;
    logic signed [63:0] r2_pv;
    t_fix               r2_w, r2_vre, r2_vim, r2_dre, r2_dim;
    t_fix               r3_kx, r3_ky, r3_v, r3_w, r3_vre, r3_vim, r3_dre, r3_dim;
    logic signed [63:0] r4_pkx, r4_pky, r4_px;
    t_fix               r4_vre, r4_vim, r4_dre, r4_dim;
    t_fix               r5_k2, r5_x, r5_vre, r5_vim, r5_dre, r5_dim;
    logic signed [63:0] r6_pk4, r6_ps, r6_py;
    t_fix               r6_vre, r6_vim, r6_dre, r6_dim;
    t_fix               r7_k4, r7_s, r7_g, r7_vre, r7_vim, r7_dre, r7_dim;
    logic signed [63:0] r8_pt1, r8_pre, r8_pim;
    t_fix               r8_vre, r8_vim, r8_g;
    t_fix               r9_t1, r9_nre, r9_nim, r9_g;
    logic signed [63:0] r10_pt;
    t_fix               r10_nre, r10_nim, r10_g;
    logic [30:0]        r11_den;
    t_fix               r11_nre, r11_nim, r11_g;
    t_fix               w_y, w_t, w_den;

    always_ff @(posedge i_clk) begin
        if (w_cf[0]) begin
            r1_kind <= i_s_axis_tuser;
            r1_fr   <= fold(w_row, r_grid_rows);
            r1_fc   <= fold(w_col, r_grid_cols);
            r1_vre  <= w_vre;
            r1_vim  <= w_vim;
            r1_dre  <= w_dre;
            r1_dim  <= w_dim;
            r1_u    <= sub_sat(ONE_FIX, w_vre);
            r1_w    <= sub_sat(ONE_FIX, add_sat(w_vre, w_vre));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cf[1]) begin
            r2_kind <= r1_kind;
            r2_pkx  <= r1_fr * $signed({1'b0, r_fsr});
            r2_pky  <= r1_fc * $signed({1'b0, r_fsc});
            r2_pv   <= r1_vre * r1_u;
            r2_w    <= r1_w;
            r2_vre  <= r1_vre;
            r2_vim  <= r1_vim;
            r2_dre  <= r1_dre;
            r2_dim  <= r1_dim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cf[2]) begin
            r3_kind <= r2_kind;
            r3_kx   <= sat44(r2_pkx);
            r3_ky   <= sat44(r2_pky);
            r3_v    <= rnd(r2_pv);
            r3_w    <= r2_w;
            r3_vre  <= r2_vre;
            r3_vim  <= r2_vim;
            r3_dre  <= r2_dre;
            r3_dim  <= r2_dim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cf[3]) begin
            r4_kind <= r3_kind;
            r4_pkx  <= r3_kx * r3_kx;
            r4_pky  <= r3_ky * r3_ky;
            r4_px   <= r3_v * r3_w;
            r4_vre  <= r3_vre;
            r4_vim  <= r3_vim;
            r4_dre  <= r3_dre;
            r4_dim  <= r3_dim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cf[4]) begin
            r5_kind <= r4_kind;
            r5_k2   <= add_sat(rnd(r4_pkx), rnd(r4_pky));
            r5_x    <= rnd(r4_px);
            r5_vre  <= r4_vre;
            r5_vim  <= r4_vim;
            r5_dre  <= r4_dre;
            r5_dim  <= r4_dim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cf[5]) begin
            r6_kind <= r5_kind;
            r6_pk4  <= r5_k2 * r5_k2;
            r6_ps   <= r5_k2 * $signed({1'b0, r_dt});
            r6_py   <= $signed({1'b0, r_bh}) * r5_x;
            r6_vre  <= r5_vre;
            r6_vim  <= r5_vim;
            r6_dre  <= r5_dre;
            r6_dim  <= r5_dim;
        end
    end

    assign w_y = rnd(r6_py);

    always_ff @(posedge i_clk) begin
        if (w_cf[6]) begin
            r7_kind <= r6_kind;
            r7_k4   <= rnd(r6_pk4);
            r7_s    <= rnd(r6_ps);
            r7_g    <= add_sat(w_y, w_y);
            r7_vre  <= r6_vre;
            r7_vim  <= r6_vim;
            r7_dre  <= r6_dre;
            r7_dim  <= r6_dim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cf[7]) begin
            r8_kind <= r7_kind;
            r8_pt1  <= $signed({1'b0, r_kap}) * r7_k4;
            r8_pre  <= r7_s * r7_dre;
            r8_pim  <= r7_s * r7_dim;
            r8_vre  <= r7_vre;
            r8_vim  <= r7_vim;
            r8_g    <= r7_g;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cf[8]) begin
            r9_kind <= r8_kind;
            r9_t1   <= rnd(r8_pt1);
            r9_nre  <= sub_sat(r8_vre, rnd(r8_pre));
            r9_nim  <= sub_sat(r8_vim, rnd(r8_pim));
            r9_g    <= r8_g;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cf[9]) begin
            r10_kind <= r9_kind;
            r10_pt   <= r9_t1 * $signed({1'b0, r_dt});
            r10_nre  <= r9_nre;
            r10_nim  <= r9_nim;
            r10_g    <= r9_g;
        end
    end

    always_comb begin
        w_t   = rnd(r10_pt);
        w_den = add_sat(ONE_FIX, add_sat(w_t, w_t));
        if (w_den < 32'sd1) begin
            w_den = 32'sd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cf[10]) begin
            r11_kind <= r10_kind;
            r11_den  <= w_den[30:0];
            r11_nre  <= r10_nre;
            r11_nim  <= r10_nim;
            r11_g    <= r10_g;
        end
    end

    t_fix w_res_re, w_res_im;

    chsu_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_vf[FRONT_ST-1]),
        .o_ready  (w_div_rdy),
        .i_num_re (r11_nre),
        .i_num_im (r11_nim),
        .i_den    (r11_den),
        .i_kind   (r11_kind),
        .i_bulk   (r11_g),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_res_re (w_res_re),
        .o_res_im (w_res_im)
    );

    assign o_s_axis_tready = w_cf[0];
    assign o_m_axis_tdata  = {w_res_im, w_res_re};

endmodule

/* hw/rtl/chsu_check.sv */
// ----------------------------------------------------------------------------
// chsu_check
// Port-level checks for the spectral update core, bound to the top level.
// ----------------------------------------------------------------------------
module chsu_check (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_s_axis_tready,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [chsu_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output item changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("pipeline not empty after reset");

    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input blocked while output stage empty");

    a_recv_ready_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> o_s_axis_tready)
        else $error("input blocked while receiver ready");

endmodule

bind cahn_hilliard_spectral_update_core chsu_check u_chsu_check (.*);

/* tb/cahn_hilliard_spectral_update_core_tb.sv */
// ----------------------------------------------------------------------------
// cahn_hilliard_spectral_update_core_tb
// Streams bulk and spectral grid points through the core under several
// register settings, with random gaps on both sides and one long output
// hold-off. Each result is checked against a fixed-point model of the step.
// ----------------------------------------------------------------------------
module cahn_hilliard_spectral_update_core_tb;
    import chsu_pkg::*;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam longint UNIT = 64'sd1048576;

    typedef struct {
        logic        kind;
        logic [9:0]  row;
        logic [9:0]  col;
        logic [31:0] c_re;
        logic [31:0] c_im;
        logic [31:0] g_re;
        logic [31:0] g_im;
    } t_point;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
    } t_update;

    function automatic longint clamp(input longint v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    // exact product, rounded half away from zero by sh bits, saturated
    function automatic longint fx_mul(input longint a, input longint b, input int sh);
        logic neg;
        logic [127:0] m;
        logic [127:0] lim;
        neg = (a < 0) != (b < 0);
        m = 128'($unsigned(a < 0 ? -a : a)) * 128'($unsigned(b < 0 ? -b : b));
        if (sh > 0) m = (m + (128'd1 << (sh - 1))) >> sh;
        lim = neg ? 128'd2147483648 : 128'd2147483647;
        if (m > lim) m = lim;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic longint fx_div(input longint n, input longint d);
        logic neg;
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] r;
        logic [127:0] lim;
        neg = n < 0;
        num = 128'($unsigned(neg ? -n : n)) << FRAC_BITS;
        q = num / 128'(d);
        r = num % 128'(d);
        if (2 * r >= 128'(d)) q = q + 1;
        lim = neg ? 128'd2147483648 : 128'd2147483647;
        if (q > lim) q = lim;
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint wave_index(input logic [9:0] idx, input logic [10:0] n);
        longint nn;
        nn = (n > 1024) ? 1024 : n;
        if (idx < nn / 2) return idx;
        return longint'(idx) - nn;
    endfunction

    class update_scoreboard;
        logic [10:0] rows, cols;
        logic [30:0] kx_step, ky_step, kappa, barrier, dt;
        t_update pending[$];
        int mismatches;

        function void reset_regs();
            rows = 11'd256; cols = 11'd256; kx_step = 31'd25736; ky_step = 31'd25736;
            kappa = 31'd1048576; barrier = 31'd1048576; dt = 31'd1048576;
        endfunction

        function void write_reg(t_reg_idx idx, logic [30:0] val);
            case (idx)
                REG_GRID_ROWS: rows = val[10:0];
                REG_GRID_COLS: cols = val[10:0];
                REG_FSTEP_ROW: kx_step = val;
                REG_FSTEP_COL: ky_step = val;
                REG_GRAD_COEFF: kappa = val;
                REG_BARRIER: barrier = val;
                REG_TIME_STEP: dt = val;
                default: ;
            endcase
        endfunction

        function void note_point(t_point p);
            longint c, v, w, y, kx, ky, k2, k4, t, den, s, nre, nim;
            t_update u;
            if (!p.kind) begin
                c = longint'($signed(p.c_re));
                v = fx_mul(c, clamp(UNIT - c), FRAC_BITS);
                w = clamp(UNIT - clamp(c + c));
                y = fx_mul(barrier, fx_mul(v, w, FRAC_BITS), FRAC_BITS);
                u.re = 32'(clamp(y + y));
                u.im = 32'd0;
            end else begin
                kx = fx_mul(wave_index(p.row, rows), kx_step, 0);
                ky = fx_mul(wave_index(p.col, cols), ky_step, 0);
                k2 = clamp(fx_mul(kx, kx, FRAC_BITS) + fx_mul(ky, ky, FRAC_BITS));
                k4 = fx_mul(k2, k2, FRAC_BITS);
                t = fx_mul(fx_mul(kappa, k4, FRAC_BITS), dt, FRAC_BITS);
                den = clamp(UNIT + clamp(t + t));
                if (den < 1) den = 1;
                s = fx_mul(k2, dt, FRAC_BITS);
                nre = clamp(longint'($signed(p.c_re))
                            - fx_mul(s, longint'($signed(p.g_re)), FRAC_BITS));
                nim = clamp(longint'($signed(p.c_im))
                            - fx_mul(s, longint'($signed(p.g_im)), FRAC_BITS));
                u.re = 32'(fx_div(nre, den));
                u.im = 32'(fx_div(nim, den));
            end
            pending.push_back(u);
        endfunction

        function void check_result(logic [63:0] data);
            t_update e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", data);
                return;
            end
            e = pending.pop_front();
            if (data[31:0] !== e.re || data[63:32] !== e.im) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected re %h im %h, got re %h im %h",
                             e.re, e.im, data[31:0], data[63:32]);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [IN_DATA_W-1:0] s_data = '0;
    logic        s_kind = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [OUT_DATA_W-1:0] m_data;
    logic        cfg_we = 0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    update_scoreboard sb = new();
    int   cycle = 0;
    bit   calm = 0;
    int   hold_off = 0;

    always #6 i_clk = ~i_clk;

    cahn_hilliard_spectral_update_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_kind),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > 400000) begin
            $display("cahn_hilliard_spectral_update_core test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) sb.check_result(m_data);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 34);
        end
    end

    task automatic send_point(t_point p);
        while (!calm && $urandom_range(99) < 34) begin
            s_valid <= 0;
            @(posedge i_clk);
        end
        s_valid <= 1;
        s_kind <= p.kind;
        s_data <= {p.g_im, p.g_re, p.c_im, p.c_re, p.col, p.row};
        do @(posedge i_clk); while (!s_ready);
        sb.note_point(p);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [30:0] val);
        @(posedge i_clk);
        cfg_we <= 1; cfg_idx <= idx; cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 0;
        sb.write_reg(idx, val);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_value(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(2097152)) - 32'sd1048576 + 32'sd524288);
            2: return 32'($signed($urandom_range(65535)) - 32'sd32768);
            default: return $urandom_range(1048576);
        endcase
    endfunction

    function automatic t_point rand_point();
        t_point p;
        p.kind = 1'($urandom_range(1));
        p.row = 10'($urandom()); p.col = 10'($urandom());
        p.c_re = rand_value($urandom_range(3));
        p.c_im = rand_value($urandom_range(3));
        p.g_re = rand_value($urandom_range(3));
        p.g_im = rand_value($urandom_range(3));
        return p;
    endfunction

    task automatic directed_set();
        logic [31:0] vals[6] = '{32'h0, 32'h7FFFFFFF, 32'h80000000,
                                 32'h00100000, 32'h00080000, 32'hFFFFFFFF};
        t_point p;
        foreach (vals[i]) begin
            p = '{1'b0, 10'h3FF, 10'h3FF, vals[i], ~vals[i], vals[i], ~vals[i]};
            send_point(p);
        end
        foreach (vals[i]) begin
            p.kind = 1;
            p.row = (i % 2) ? 10'h3FF : 10'(i * 64);
            p.col = (i % 3 == 0) ? 10'd0 : 10'(128 + i);
            p.c_re = vals[i]; p.c_im = vals[5 - i];
            p.g_re = vals[(i + 2) % 6]; p.g_im = vals[(i + 3) % 6];
            send_point(p);
        end
    endtask

    task automatic random_run(int n);
        repeat (n) send_point(rand_point());
    endtask

    initial begin
        sb.reset_regs();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        directed_set();
        random_run(60);
        drain();

        write_reg(REG_GRID_ROWS, 2);    write_reg(REG_GRID_COLS, 11'h7FF);
        write_reg(REG_FSTEP_ROW, 31'h7FFFFFFF); write_reg(REG_FSTEP_COL, 0);
        write_reg(REG_GRAD_COEFF, 0);   write_reg(REG_BARRIER, 31'h7FFFFFFF);
        write_reg(REG_TIME_STEP, 31'h7FFFFFFF);
        directed_set();
        random_run(80);
        drain();

        write_reg(REG_GRID_ROWS, 1);    write_reg(REG_GRID_COLS, 0);
        write_reg(REG_FSTEP_ROW, 1000); write_reg(REG_FSTEP_COL, 3000);
        write_reg(REG_GRAD_COEFF, 31'h7FFFFFFF); write_reg(REG_BARRIER, 0);
        write_reg(REG_TIME_STEP, 0);
        random_run(80);
        drain();

        write_reg(REG_GRID_ROWS, 1024); write_reg(REG_GRID_COLS, 64);
        write_reg(REG_FSTEP_ROW, 6434); write_reg(REG_FSTEP_COL, 102944);
        write_reg(REG_GRAD_COEFF, 524288); write_reg(REG_BARRIER, 2097152);
        write_reg(REG_TIME_STEP, 10486);
        @(posedge i_clk);
        hold_off <= 200;
        random_run(150);
        calm = 1;
        random_run(120);
        calm = 0;
        random_run(130);

        drain();
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("cahn_hilliard_spectral_update_core test passed");
        end else begin
            $display("cahn_hilliard_spectral_update_core test failed");
        end
        $finish;
    end
endmodule

/* sim.f */
hw/rtl/chsu_pkg.sv
hw/rtl/chsu_div.sv
hw/rtl/cahn_hilliard_spectral_update_core.sv
hw/rtl/chsu_check.sv
tb/cahn_hilliard_spectral_update_core_tb.sv
